/* hdl/iirl_pkg.sv */
package iirl_pkg;

	localparam int CAPACITY = 64;
	localparam int DATA_WIDTH = 32;
	localparam int POS_W = 6;
	localparam int CNT_W = 7;
	localparam int VAL_W = 32;
	localparam int GROUP = 8;
	localparam int NGRP = (CAPACITY + GROUP - 1) / GROUP;

	localparam logic [1:0] REQ_GET = 2'd0;
	localparam logic [1:0] REQ_SET = 2'd1;
	localparam logic [1:0] REQ_INSERT = 2'd2;
	localparam logic [1:0] REQ_REMOVE = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_INDEX = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]       req_type;
		logic [POS_W-1:0] position;
		logic [VAL_W-1:0] item_value;
	} req_t;

	typedef struct packed {
		logic [VAL_W-1:0] read_value;
		logic [1:0]       status;
		logic [CNT_W-1:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic                  rd_en;
		logic                  set_en;
		logic                  ins_en;
		logic                  rem_en;
		logic [POS_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] value;
	} cell_cmd_t;

endpackage

/* hdl/iirl_cell.sv */
module iirl_cell
	import iirl_pkg::*;
(
	input  logic                  clk,
	input  logic [POS_W-1:0]      idx,
	input  cell_cmd_t             cmd,
	input  logic [DATA_WIDTH-1:0] left,
	input  logic [DATA_WIDTH-1:0] right,
	output logic [DATA_WIDTH-1:0] data,
	output logic [DATA_WIDTH-1:0] rd_s1
);

	logic [DATA_WIDTH-1:0] data_q;
	logic                  here;
	logic                  above;

	assign here  = (idx == cmd.pos);
	assign above = (idx > cmd.pos);
	assign data  = data_q;

	always_ff @(posedge clk) begin
		if (cmd.set_en && here) begin
			data_q <= cmd.value;
		end else if (cmd.ins_en && above) begin
			data_q <= left;
		end else if (cmd.ins_en && here) begin
			data_q <= cmd.value;
		end else if (cmd.rem_en && (here || above)) begin
			data_q <= right;
		end
		if (cmd.rd_en) begin
			rd_s1 <= here ? data_q : '0;
		end
	end

endmodule

/* hdl/iirl_gather.sv */
module iirl_gather
	import iirl_pkg::*;
(
	input  logic                  clk,
	input  logic [DATA_WIDTH-1:0] taps [CAPACITY],
	output logic [DATA_WIDTH-1:0] grp_s2 [NGRP]
);

	logic [DATA_WIDTH-1:0] grp_d [NGRP];

	always_comb begin
		for (int g = 0; g < NGRP; g++) begin
			grp_d[g] = '0;
			for (int k = 0; k < GROUP; k++) begin
				if (g * GROUP + k < CAPACITY) begin
					grp_d[g] = grp_d[g] | taps[g * GROUP + k];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		grp_s2 <= grp_d;
	end

endmodule

/* hdl/indexed_insert_remove_list.sv */
// Channel   Payload  Handshake            Direction
// req       req_t    req_valid/req_stall  into the block
// rsp       rsp_t    rsp_valid/rsp_stall  out of the block
//
// A transaction is accepted only in the idle state; after the accepting edge the
// block passes through TAP and GATHER, and its response is valid in RESP, which
// holds while rsp_stall is asserted. The list is a row of cells that
// shift in parallel; the read path gathers the addressed cell through two
// registered OR stages. Reset clears the entry count and the control state;
// cell contents are undefined until written. Input stalls until the previous
// response has been taken.
module indexed_insert_remove_list
	import iirl_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [1:0] {
		IDLE,
		TAP,
		GATHER,
		RESP
	} state_t;

	state_t                state_q;
	logic [CNT_W-1:0]      cnt_q;
	logic [1:0]            status_q;
	logic                  rd_sel_q;
	rsp_t                  rsp_q;

	logic                  acc;
	logic [CNT_W-1:0]      pos_ext;
	logic                  in_range;
	logic [1:0]            status_d;
	logic [CNT_W-1:0]      cnt_d;
	logic                  rd_sel_d;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] taps [CAPACITY];
	logic [DATA_WIDTH-1:0] grp_s2 [NGRP];
	logic [DATA_WIDTH-1:0] gathered;

	assign req_stall = (state_q != IDLE);
	assign acc = req_valid && !req_stall;
	assign pos_ext = CNT_W'(req.position);
	assign in_range = (pos_ext < cnt_q);

	always_comb begin
		status_d = ST_OK;
		cnt_d = cnt_q;
		rd_sel_d = 1'b0;
		cmd.rd_en = acc;
		cmd.set_en = 1'b0;
		cmd.ins_en = 1'b0;
		cmd.rem_en = 1'b0;
		cmd.pos = req.position;
		cmd.value = DATA_WIDTH'(req.item_value);
		case (req.req_type)
			REQ_GET: begin
				if (in_range) begin
					rd_sel_d = 1'b1;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			REQ_SET: begin
				if (in_range) begin
					cmd.set_en = acc;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			REQ_INSERT: begin
				if (pos_ext > cnt_q) begin
					status_d = ST_BAD_INDEX;
				end else if (cnt_q == CNT_W'(CAPACITY)) begin
					status_d = ST_FULL;
				end else begin
					cmd.ins_en = acc;
					cnt_d = cnt_q + 1'b1;
				end
			end
			REQ_REMOVE: begin
				if (in_range) begin
					rd_sel_d = 1'b1;
					cmd.rem_en = acc;
					cnt_d = cnt_q - 1'b1;
				end else begin
					status_d = ST_BAD_INDEX;
				end
			end
			default: begin
				status_d = ST_BAD_INDEX;
			end
		endcase
	end

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_d;
		logic [DATA_WIDTH-1:0] right_d;
		if (i == 0) begin : g_first
			assign left_d = '0;
		end else begin : g_mid_l
			assign left_d = cell_data[i-1];
		end
		if (i == CAPACITY - 1) begin : g_last
			assign right_d = '0;
		end else begin : g_mid_r
			assign right_d = cell_data[i+1];
		end
		iirl_cell u_cell (
			.clk   (clk),
			.idx   (POS_W'(i)),
			.cmd   (cmd),
			.left  (left_d),
			.right (right_d),
			.data  (cell_data[i]),
			.rd_s1 (taps[i])
		);
	end

	iirl_gather u_gather (
		.clk    (clk),
		.taps   (taps),
		.grp_s2 (grp_s2)
	);

	always_comb begin
		gathered = '0;
		for (int g = 0; g < NGRP; g++) begin
			gathered = gathered | grp_s2[g];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= IDLE;
			cnt_q <= '0;
			status_q <= ST_OK;
			rd_sel_q <= 1'b0;
			rsp_q <= '0;
		end else begin
			case (state_q)
				IDLE: begin
					if (acc) begin
						state_q <= TAP;
						cnt_q <= cnt_d;
						status_q <= status_d;
						rd_sel_q <= rd_sel_d;
					end
				end
				TAP: begin
					state_q <= GATHER;
				end
				GATHER: begin
					state_q <= RESP;
					rsp_q.read_value <= rd_sel_q ? VAL_W'(gathered) : '0;
					rsp_q.status <= status_q;
					rsp_q.entry_count <= cnt_q;
				end
				RESP: begin
					if (!rsp_stall) begin
						state_q <= IDLE;
					end
				end
				default: begin
					state_q <= IDLE;
				end
			endcase
		end
	end

	assign rsp_valid = (state_q == RESP);
	assign rsp = rsp_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(CAPACITY))
		else $error("entry count exceeds capacity");

	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!acc |=> $stable(cnt_q))
		else $error("entry count changed without a transaction");

	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == ST_FULL |-> rsp.entry_count == CNT_W'(CAPACITY))
		else $error("full status with list not full");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.read_value == '0)
		else $error("nonzero read value on error");

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> ##2 rsp_valid)
		else $error("response not ready three cycles after acceptance");
`endif

endmodule
